[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define QTE_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define QTE_ASSERT(lbl, prop, msg) \
  `QTE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[hw/rtl/qte_pkg.sv]
`default_nettype none
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN = 24;
  localparam int NSTAGE = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int SQRT_STAGES = 31;

  localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [33:0] rn;
    logic signed [33:0] rd;
    logic signed [33:0] yn;
    logic signed [33:0] yd;
    logic signed [31:0] s;
    logic               clamped;
  } pl_t;

  typedef struct packed {
    logic [60:0] rem;
    logic [61:0] root;
    pl_t         pl;
  } sq_t;

  typedef struct packed {
    logic               zero;
    logic signed [36:0] x;
    logic signed [36:0] y;
    logic [31:0]        ang;
  } lane_t;

  typedef struct packed {
    lane_t [2:0] ln;
    logic        clamped;
  } cd_t;

  function automatic lane_t lane_init(logic signed [36:0] y, logic signed [36:0] x);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      l.x   = -x;
      l.y   = -y;
      l.ang = 32'h8000_0000;
    end else begin
      l.x   = x;
      l.y   = y;
      l.ang = '0;
    end
    return l;
  endfunction

  function automatic lane_t cordic_step(lane_t l, logic [4:0] idx);
    lane_t r;
    logic signed [36:0] xs;
    logic signed [36:0] ys;
    xs = l.x >>> idx;
    ys = l.y >>> idx;
    r.zero = l.zero;
    if (l.y >= 0) begin
      r.x   = l.x + ys;
      r.y   = l.y - xs;
      r.ang = l.ang + ATAN_TABLE[idx];
    end else begin
      r.x   = l.x - ys;
      r.y   = l.y + xs;
      r.ang = l.ang - ATAN_TABLE[idx];
    end
    return r;
  endfunction

  function automatic logic [15:0] to_angle16(lane_t l);
    logic [31:0] a;
    a = l.ang + 32'h0000_8000;
    return l.zero ? 16'h0000 : a[31:16];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/qte_sqrt_cell.sv]
`default_nettype none
module qte_sqrt_cell (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic [4:0]   k_i,
  input  wire logic         valid_i,
  input  wire qte_pkg::sq_t data_i,
  output logic              valid_o,
  output qte_pkg::sq_t      data_o
);
  import qte_pkg::*;

  logic        valid_q;
  sq_t         data_q;
  sq_t         data_d;
  logic [61:0] bitv;
  logic [61:0] trial;

  always_comb begin
    bitv   = 62'd1 << {k_i, 1'b0};
    trial  = data_i.root + bitv;
    data_d = data_i;
    if ({1'b0, data_i.rem} >= trial) begin
      data_d.rem  = data_i.rem - trial[60:0];
      data_d.root = (data_i.root >> 1) + bitv;
    end else begin
      data_d.root = data_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

[hw/rtl/qte_cordic_cell.sv]
`default_nettype none
module qte_cordic_cell (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic [4:0]   idx_i,
  input  wire logic         valid_i,
  input  wire qte_pkg::cd_t data_i,
  output logic              valid_o,
  output qte_pkg::cd_t      data_o
);
  import qte_pkg::*;

  logic valid_q;
  cd_t  data_q;
  cd_t  data_d;

  always_comb begin
    data_d.clamped = data_i.clamped;
    for (int j = 0; j < 3; j++) begin
      data_d.ln[j] = cordic_step(data_i.ln[j], idx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

[hw/rtl/quaternion_to_euler_angles_top.sv]
// Quaternion to ZYX Euler angles (roll, pitch, yaw).
// Input stream: s_axis_tdata carries w, x, y, z as signed Q1.15 values.
// Output stream: m_axis_tdata carries roll, pitch and yaw as 16-bit binary
// angles (32768 = pi); m_axis_tuser flags a pitch sine that was saturated.
// One request enters per cycle while the pipeline advances. The block is a
// fixed pipeline: four product, sum, square and radicand stages, 31
// square-root cells (one result bit each), one CORDIC setup stage, NSTAGE
// CORDIC cells (16 by default) and the output register.
// Throughput is one result per cycle while the receiver takes them, set by
// the one-bit-per-cell root chain and one-rotation-per-cell CORDIC chain.
// The whole pipeline advances when the output register is empty or taken;
// while the receiver stalls with a result waiting, it holds and tready drops.
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
`default_nettype none
`include "assert_macros.svh"
module quaternion_to_euler_angles_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // roll_angle, pitch_angle, yaw_angle
  output logic             m_axis_tuser   // pitch_clamped
);
  import qte_pkg::*;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [15:0] w, x, y, z;
  assign w = s_axis_tdata[15:0];
  assign x = s_axis_tdata[31:16];
  assign y = s_axis_tdata[47:32];
  assign z = s_axis_tdata[63:48];

  // stage 1: products
  logic v1_q;
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;

  // stage 2: sums and saturation
  logic v2_q;
  pl_t  p2_q, p2_d;
  logic signed [33:0] sraw;

  // stage 3: square of sine
  logic v3_q;
  pl_t  p3_q;
  logic signed [63:0] sq_q;

  // stage 4: radicand
  logic v4_q;
  sq_t  r4_q;

  always_comb begin
    p2_d.rn = (34'(wx_q) + 34'(yz_q)) <<< 1;
    p2_d.rd = 34'sh0_4000_0000 - ((34'(xx_q) + 34'(yy_q)) <<< 1);
    p2_d.yn = (34'(wz_q) + 34'(xy_q)) <<< 1;
    p2_d.yd = 34'sh0_4000_0000 - ((34'(yy_q) + 34'(zz_q)) <<< 1);
    sraw    = (34'(wy_q) - 34'(zx_q)) <<< 1;
    p2_d.clamped = 1'b0;
    if (sraw > 34'sh0_4000_0000) begin
      p2_d.s = 32'sh4000_0000;
      p2_d.clamped = 1'b1;
    end else if (sraw < -34'sh0_4000_0000) begin
      p2_d.s = -32'sh4000_0000;
      p2_d.clamped = 1'b1;
    end else begin
      p2_d.s = sraw[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= w * x;
      yz_q <= y * z;
      xx_q <= x * x;
      yy_q <= y * y;
      wz_q <= w * z;
      xy_q <= x * y;
      zz_q <= z * z;
      wy_q <= w * y;
      zx_q <= z * x;
      p2_q <= p2_d;
      p3_q <= p2_q;
      sq_q <= p2_q.s * p2_q.s;
      r4_q.pl   <= p3_q;
      r4_q.root <= '0;
      r4_q.rem  <= 61'h1000_0000_0000_0000 - sq_q[60:0];
    end
  end

  // square-root chain
  logic sv [SQRT_STAGES+1];
  sq_t  sd [SQRT_STAGES+1];
  assign sv[0] = v4_q;
  assign sd[0] = r4_q;

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    qte_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .k_i     (5'(SQRT_STAGES - 1 - j)),
      .valid_i (sv[j]),
      .data_i  (sd[j]),
      .valid_o (sv[j+1]),
      .data_o  (sd[j+1])
    );
  end

  // CORDIC setup
  logic vp_q;
  cd_t  cp_q, cp_d;
  pl_t  pf;
  assign pf = sd[SQRT_STAGES].pl;

  always_comb begin
    cp_d.clamped = pf.clamped;
    cp_d.ln[0] = lane_init(37'(pf.rn), 37'(pf.rd));
    cp_d.ln[1] = lane_init(37'(pf.s), {6'd0, sd[SQRT_STAGES].root[30:0]});
    cp_d.ln[2] = lane_init(37'(pf.yn), 37'(pf.yd));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= sv[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cp_q <= cp_d;
    end
  end

  // CORDIC chain
  logic cv [NSTAGE+1];
  cd_t  cd [NSTAGE+1];
  assign cv[0] = vp_q;
  assign cd[0] = cp_q;

  for (genvar i = 0; i < NSTAGE; i++) begin : g_cordic
    qte_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (5'(i)),
      .valid_i (cv[i]),
      .data_i  (cd[i]),
      .valid_o (cv[i+1]),
      .data_o  (cd[i+1])
    );
  end

  // output register
  logic               vo_q;
  logic [47:0]        do_q;
  logic               uo_q;
  logic signed [15:0] pa;
  logic signed [15:0] pc;

  always_comb begin
    pa = to_angle16(cd[NSTAGE].ln[1]);
    if (pa > 16'sd16384) begin
      pc = 16'sd16384;
    end else if (pa < -16'sd16384) begin
      pc = -16'sd16384;
    end else begin
      pc = pa;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= cv[NSTAGE];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      do_q <= {to_angle16(cd[NSTAGE].ln[2]), pc, to_angle16(cd[NSTAGE].ln[0])};
      uo_q <= cd[NSTAGE].clamped;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = do_q;
  assign m_axis_tuser  = uo_q;

  logic signed [15:0] pitch_out;
  logic               pitch_ok;
  assign pitch_out = m_axis_tdata[31:16];
  assign pitch_ok  = (pitch_out <= 16'sd16384) && (pitch_out >= -16'sd16384);

  `QTE_ASSERT(a_pitch_range, m_axis_tvalid |-> pitch_ok, "pitch out of range")
  `QTE_ASSERT(a_ready_rule, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready mismatch")
  `QTE_ASSERT(a_enter, (s_axis_tvalid && s_axis_tready) |=> v1_q, "request lost at entry")
endmodule
`default_nettype wire
